// ===== hdl/assert_macros.svh =====
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PBRLE_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PBRLE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pbrle_pkg.sv =====
// package: types, constants and helpers of the packbits encoder
`default_nettype none

package pbrle_pkg;

	localparam int BYTE_W     = 8;
	localparam int LANES      = 8;
	localparam int OUT_W      = LANES * BYTE_W;
	localparam int CNT_W      = $clog2(LANES + 1);
	localparam int LANE_AW    = $clog2(LANES);
	localparam int MAX_PACKET = 128;
	localparam int LIT_AW     = $clog2(MAX_PACKET);
	localparam int LEN_W      = $clog2(MAX_PACKET + 1);
	localparam int RUN_BIAS   = 257;

	localparam logic [BYTE_W-1:0] EOD_BYTE = 8'h80;
	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

	typedef logic [BYTE_W:0] wide_byte_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN_HDR,
		ST_RUN_VAL,
		ST_LIT_HDR,
		ST_LIT_DATA,
		ST_EOD,
		ST_PAD
	} pbrle_state_t;

	// packet sections still owed for the current item, in emission order
	typedef struct packed {
		logic run_a;
		logic lit;
		logic run_b;
		logic eod;
	} pbrle_pend_t;

	function automatic pbrle_state_t first_phase(input pbrle_pend_t p);
		pbrle_state_t s;
		priority if (p.run_a) s = ST_RUN_HDR;
		else if (p.lit)       s = ST_LIT_HDR;
		else if (p.run_b)     s = ST_RUN_HDR;
		else if (p.eod)       s = ST_EOD;
		else                  s = ST_IDLE;
		return s;
	endfunction

	// run header 257 - length, kept to one byte
	function automatic logic [BYTE_W-1:0] run_hdr(input logic [LEN_W-1:0] len);
		wide_byte_t t;
		t = wide_byte_t'(RUN_BIAS) - wide_byte_t'(len);
		return t[BYTE_W-1:0];
	endfunction

	// residue modulo 3 of a small sum
	function automatic logic [1:0] mod3_small(input logic [CNT_W:0] v);
		logic [CNT_W:0] r;
		r = v;
		for (int i = 0; i < 4; i++) begin
			if (r >= (CNT_W + 1)'(3)) begin
				r = r - (CNT_W + 1)'(3);
			end
		end
		return r[1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pbrle_if.sv =====
// interfaces of the input byte channel and the packed result channel
`default_nettype none

interface pbrle_in_if;
	logic                          valid;
	logic                          ready;
	logic [pbrle_pkg::BYTE_W-1:0]  in_byte;
	logic                          last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface pbrle_out_if;
	logic                          valid;
	logic                          ready;
	logic [pbrle_pkg::OUT_W-1:0]   out_bytes;
	logic [pbrle_pkg::CNT_W-1:0]   byte_count;
	logic                          last_of_item;
	logic                          stream_end;

	modport source (output valid, output out_bytes, output byte_count,
		output last_of_item, output stream_end, input ready);
	modport sink   (input valid, input out_bytes, input byte_count,
		input last_of_item, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/pbrle_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module pbrle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/packbits_rle_encoder.sv =====
// top level: packbits run-length encoder with byte-serial packet emitter
`default_nettype none

// channel   role     transfer moves
// in_ch     sink     one raw byte, last_byte flags the stream's final byte
// out_ch    source   up to eight encoded bytes, first byte in bits 7:0
//
// an item that is only buffered leaves the encoder idle, and the next may follow at once
// an item that emits bytes holds off the input until it is done: the emitter moves one byte per
//   cycle into the packing word while the output register can take it
// the emitter holds whenever the output register is full and not taken
// arst_n clears all control state; the literal ram needs no clearing pass

module packbits_rle_encoder (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pbrle_in_if.sink    in_ch,
	pbrle_out_if.source out_ch
);

	// encoder state
	logic [pbrle_pkg::LEN_W-1:0]  lit_len_q, lit_len_n;
	logic [pbrle_pkg::BYTE_W-1:0] prev_q, prev_n;      // last byte of the literal
	logic                         run_act_q, run_act_n;
	logic [pbrle_pkg::BYTE_W-1:0] run_v_q, run_v_n;
	logic [pbrle_pkg::LEN_W-1:0]  run_len_q, run_len_n;
	logic [1:0]                   mod3_q, mod3_inc;

	// sequencer
	pbrle_pkg::pbrle_state_t      state_q, state_d;
	pbrle_pkg::pbrle_pend_t       pend_q, pend_d, acc_pend;
	logic [pbrle_pkg::LIT_AW-1:0] idx_q, idx_d;

	// packets owed for the current item
	logic [pbrle_pkg::BYTE_W-1:0] run_hdr_q, run_val_q, acc_hdr, acc_val;
	logic [pbrle_pkg::LIT_AW-1:0] lit_hdr_q, acc_lit_hdr;

	// packing word and output register
	logic [pbrle_pkg::OUT_W-1:0]   bld_q, bld_n;
	logic [pbrle_pkg::LANE_AW-1:0] bld_cnt_q;
	logic                          bld_end_q;
	logic [pbrle_pkg::OUT_W-1:0]   out_word_q;
	logic [pbrle_pkg::CNT_W-1:0]   out_cnt_q;
	logic                          out_valid_q, out_last_q, out_end_q;

	logic                         accept, buf_we, taken;
	logic                         out_free, go, fin, push, is_end;
	logic [pbrle_pkg::BYTE_W-1:0] emit_byte, rd_data;

	assign in_ch.ready = (state_q == pbrle_pkg::ST_IDLE);
	assign accept      = in_ch.valid & in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_bytes    = out_word_q;
	assign out_ch.byte_count   = out_cnt_q;
	assign out_ch.last_of_item = out_last_q;
	assign out_ch.stream_end   = out_end_q;

	// literal bytes; the read address runs one step ahead so that rd_data
	// always holds the entry at idx_q
	pbrle_ram #(
		.WIDTH(pbrle_pkg::BYTE_W),
		.DEPTH(pbrle_pkg::MAX_PACKET)
	) u_lit_ram (
		.clk  (clk),
		.we   (accept && buf_we),
		.waddr(lit_len_q[pbrle_pkg::LIT_AW-1:0]),
		.wdata(in_ch.in_byte),
		.raddr(idx_d),
		.rdata(rd_data)
	);

	// scan decision for an incoming byte: which packets close, what opens
	always_comb begin
		acc_pend    = '0;
		acc_hdr     = run_hdr_q;
		acc_val     = run_val_q;
		acc_lit_hdr = lit_hdr_q;
		buf_we      = 1'b0;
		taken       = 1'b0;
		lit_len_n   = lit_len_q;
		prev_n      = prev_q;
		run_act_n   = run_act_q;
		run_v_n     = run_v_q;
		run_len_n   = run_len_q;

		if (run_act_q) begin
			if (in_ch.in_byte == run_v_q) begin
				// run grows, closes when it reaches the packet limit
				taken     = 1'b1;
				run_len_n = run_len_q + pbrle_pkg::LEN_W'(1);
				if (run_len_n == pbrle_pkg::LEN_W'(pbrle_pkg::MAX_PACKET)) begin
					acc_pend.run_a = 1'b1;
					acc_hdr        = pbrle_pkg::run_hdr(run_len_n);
					acc_val        = run_v_q;
					run_act_n      = 1'b0;
					run_len_n      = '0;
				end
			end else begin
				// different byte ends the run, byte then starts a fresh scan
				acc_pend.run_a = 1'b1;
				acc_hdr        = pbrle_pkg::run_hdr(run_len_q);
				acc_val        = run_v_q;
				run_act_n      = 1'b0;
				run_len_n      = '0;
			end
		end

		if (!taken) begin
			if (lit_len_q != '0 && prev_q == in_ch.in_byte) begin
				// pair found: literal without the pair goes out, run opens
				if (lit_len_q > pbrle_pkg::LEN_W'(1)) begin
					acc_pend.lit = 1'b1;
					acc_lit_hdr  = pbrle_pkg::LIT_AW'(lit_len_q - pbrle_pkg::LEN_W'(2));
				end
				lit_len_n = '0;
				run_act_n = 1'b1;
				run_v_n   = in_ch.in_byte;
				run_len_n = pbrle_pkg::LEN_W'(2);
				if (run_len_n == pbrle_pkg::LEN_W'(pbrle_pkg::MAX_PACKET)) begin
					acc_pend.run_b = 1'b1;
					acc_hdr        = pbrle_pkg::run_hdr(run_len_n);
					acc_val        = in_ch.in_byte;
					run_act_n      = 1'b0;
					run_len_n      = '0;
				end
			end else begin
				buf_we    = 1'b1;
				prev_n    = in_ch.in_byte;
				lit_len_n = lit_len_q + pbrle_pkg::LEN_W'(1);
				if (lit_len_n == pbrle_pkg::LEN_W'(pbrle_pkg::MAX_PACKET)) begin
					acc_pend.lit = 1'b1;
					acc_lit_hdr  = pbrle_pkg::LIT_AW'(lit_len_q);
					lit_len_n    = '0;
				end
			end
		end

		if (in_ch.last_byte) begin
			// flush open packets, then end of data and padding
			if (run_act_n) begin
				acc_pend.run_b = 1'b1;
				acc_hdr        = pbrle_pkg::run_hdr(run_len_n);
				acc_val        = run_v_n;
			end
			if (lit_len_n != '0) begin
				acc_pend.lit = 1'b1;
				acc_lit_hdr  = pbrle_pkg::LIT_AW'(lit_len_n - pbrle_pkg::LEN_W'(1));
			end
			acc_pend.eod = 1'b1;
			lit_len_n    = '0;
			run_act_n    = 1'b0;
			run_v_n      = '0;
			run_len_n    = '0;
		end
	end

	assign mod3_inc = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;

	// emitter sequencer: one byte per cycle while the output side can take it
	always_comb begin
		pbrle_pkg::pbrle_pend_t pend_n;
		pend_n    = pend_q;
		state_d   = state_q;
		pend_d    = pend_q;
		idx_d     = idx_q;
		emit_byte = '0;
		is_end    = 1'b0;
		go        = (state_q != pbrle_pkg::ST_IDLE) && out_free;

		unique case (state_q)
			pbrle_pkg::ST_IDLE: begin
				idx_d = '0;
				if (accept) begin
					pend_d  = acc_pend;
					state_d = pbrle_pkg::first_phase(acc_pend);
				end
			end
			pbrle_pkg::ST_RUN_HDR: begin
				emit_byte = run_hdr_q;
				if (go) begin
					state_d = pbrle_pkg::ST_RUN_VAL;
				end
			end
			pbrle_pkg::ST_RUN_VAL: begin
				emit_byte = run_val_q;
				if (go) begin
					if (pend_q.run_a) begin
						pend_n.run_a = 1'b0;
					end else begin
						pend_n.run_b = 1'b0;
					end
					pend_d  = pend_n;
					state_d = pbrle_pkg::first_phase(pend_n);
				end
			end
			pbrle_pkg::ST_LIT_HDR: begin
				emit_byte = pbrle_pkg::BYTE_W'(lit_hdr_q);
				if (go) begin
					state_d = pbrle_pkg::ST_LIT_DATA;
				end
			end
			pbrle_pkg::ST_LIT_DATA: begin
				emit_byte = rd_data;
				if (go) begin
					if (idx_q == lit_hdr_q) begin
						pend_n.lit = 1'b0;
						pend_d     = pend_n;
						state_d    = pbrle_pkg::first_phase(pend_n);
						idx_d      = '0;
					end else begin
						idx_d = idx_q + pbrle_pkg::LIT_AW'(1);
					end
				end
			end
			pbrle_pkg::ST_EOD: begin
				emit_byte = pbrle_pkg::EOD_BYTE;
				is_end    = 1'b1;
				if (go) begin
					pend_n.eod = 1'b0;
					pend_d     = pend_n;
					state_d    = (mod3_inc == 2'd0) ? pbrle_pkg::ST_IDLE : pbrle_pkg::ST_PAD;
				end
			end
			pbrle_pkg::ST_PAD: begin
				emit_byte = pbrle_pkg::PAD_BYTE;
				is_end    = 1'b1;
				if (go && mod3_inc == 2'd0) begin
					state_d = pbrle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbrle_pkg::ST_IDLE;
			end
		endcase
	end

	// final byte of the item, or a full word, hands the packing word over
	assign fin  = go && (state_d == pbrle_pkg::ST_IDLE);
	assign push = go && (fin || bld_cnt_q == pbrle_pkg::LANE_AW'(pbrle_pkg::LANES - 1));

	always_comb begin
		bld_n = (bld_cnt_q == '0) ? '0 : bld_q;
		bld_n[bld_cnt_q * pbrle_pkg::BYTE_W +: pbrle_pkg::BYTE_W] = emit_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbrle_pkg::ST_IDLE;
			pend_q      <= '0;
			idx_q       <= '0;
			lit_len_q   <= '0;
			prev_q      <= '0;
			run_act_q   <= 1'b0;
			run_v_q     <= '0;
			run_len_q   <= '0;
			mod3_q      <= '0;
			bld_cnt_q   <= '0;
			bld_end_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			idx_q   <= idx_d;
			if (accept) begin
				lit_len_q <= lit_len_n;
				prev_q    <= prev_n;
				run_act_q <= run_act_n;
				run_v_q   <= run_v_n;
				run_len_q <= run_len_n;
			end
			if (go) begin
				mod3_q <= mod3_inc;
				if (push) begin
					bld_cnt_q <= '0;
					bld_end_q <= 1'b0;
				end else begin
					bld_cnt_q <= bld_cnt_q + pbrle_pkg::LANE_AW'(1);
					bld_end_q <= bld_end_q | is_end;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			run_hdr_q <= acc_hdr;
			run_val_q <= acc_val;
			lit_hdr_q <= acc_lit_hdr;
		end
		if (go) begin
			bld_q <= bld_n;
		end
		if (push) begin
			out_word_q <= bld_n;
			out_cnt_q  <= pbrle_pkg::CNT_W'(bld_cnt_q) + pbrle_pkg::CNT_W'(1);
			out_last_q <= fin;
			out_end_q  <= bld_end_q | is_end;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pbrle_chk.sv =====
// port-level checker for the packbits encoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module pbrle_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          in_last,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [pbrle_pkg::OUT_W-1:0]   out_bytes,
	input wire logic [pbrle_pkg::CNT_W-1:0]   out_count,
	input wire logic                          out_last,
	input wire logic                          out_end
);

	logic       out_xfer, end_xfer;
	logic [1:0] len_mod3_q, len_mod3_n;

	assign out_xfer   = out_valid && out_ready;
	assign end_xfer   = out_xfer && out_end && out_last;
	assign len_mod3_n = pbrle_pkg::mod3_small({1'b0, out_count} + (pbrle_pkg::CNT_W + 1)'(len_mod3_q));

	// output bytes of the current stream, modulo 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_mod3_q <= '0;
		end else if (end_xfer) begin
			len_mod3_q <= '0;
		end else if (out_xfer) begin
			len_mod3_q <= len_mod3_n;
		end
	end

	// a short word only closes an item
	`PBRLE_ASSERT_SAME(a_short_is_last, clk, arst_n,
		out_valid && out_count != pbrle_pkg::CNT_W'(pbrle_pkg::LANES), out_last,
		"partial result word that does not close its item")

	// padding brings the stream length to a multiple of three
	`PBRLE_ASSERT_SAME(a_pad_mod3, clk, arst_n, end_xfer, len_mod3_n == 2'd0,
		"stream length not a multiple of three at end of data")

	// a last byte always produces output, so the input side must hold off
	`PBRLE_ASSERT_NEXT(a_last_busy, clk, arst_n, in_valid && in_ready && in_last, !in_ready,
		"input taken right after the last byte of a stream")

	// a held result keeps its payload
	`PBRLE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_bytes) && $stable(out_count),
		"result changed while stalled")

endmodule

bind packbits_rle_encoder pbrle_chk u_pbrle_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_last  (in_ch.last_byte),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_bytes(out_ch.out_bytes),
	.out_count(out_ch.byte_count),
	.out_last (out_ch.last_of_item),
	.out_end  (out_ch.stream_end)
);

`default_nettype wire
